// ===== hw/rtl/debf_pkg.sv =====
// Shared types and constants for the distinct event burst filter.
package debf_pkg;

    // Default configuration of the candidate chain
    localparam int MAX_DISTINCT_DEF = 4;
    localparam int INDEX_BITS_DEF   = 16;

    // Field widths fixed by the interface
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 16;
    localparam int TICK_W  = 16;

    localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = 16'd200;

    // Event codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_GESTURE = 2'd0,
        MODE_CHANGE  = 2'd1,
        MODE_TICK    = 2'd2,
        MODE_DISARM  = 2'd3
    } t_mode;

    // Control states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

// ===== hw/rtl/distinct_event_burst_filter_top.sv =====
// Top level of the distinct event burst filter: control, timer and cell chain.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one event item per accepted edge:
//   gesture start, value change, tick or disarm. Output channel
//   (o_valid / i_stall) returns touched indices from a registered output stage.
//   The window length register is written through i_cfg_valid / o_cfg_ready
//   with i_cfg_data; the user must do so only while the block is idle, which
//   the block does not enforce. o_cfg_ready is always high. A gesture start
//   gives its single result in the cycle after acceptance. Value changes and
//   most ticks give no result. A tick that closes a clean window starts a
//   drain: the cell chain shifts one stored index per cycle into the output
//   stage, so a window with N candidates gives N results, the last one
//   marked. While draining o_stall stays high.
//   When the receiver stalls, the output stage holds its item, the drain
//   pauses, and o_stall stays high until the stage can take a new item.
//   Reset clears the window, counters and output stage and loads a window
//   length of 200 ticks; the cell contents stay undefined until written.
module distinct_event_burst_filter_top
    import debf_pkg::*;
#(
    parameter int MAX_DISTINCT = MAX_DISTINCT_DEF,
    parameter int INDEX_BITS   = INDEX_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // event input
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [INDEX_W-1:0] i_param_index,
    input  logic               i_already_in_layout,
    // result output
    output logic               o_valid,
    input  logic               i_stall,
    output logic [INDEX_W-1:0] o_touched_index,
    output logic               o_from_window,
    output logic               o_last,
    // window length register
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [TICK_W-1:0]  i_cfg_data
);

    localparam int STORE_BITS = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
    localparam int CNT_W      = $clog2(MAX_DISTINCT + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DISTINCT);

    // Registers
    t_state              r_state;
    logic [TICK_W-1:0]   r_window_ticks;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_left;
    logic                r_open;
    logic                r_exceeded;
    logic [TICK_W-1:0]   r_elapsed;
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_index;
    logic                r_out_window;
    logic                r_out_last;

    t_state              n_state;
    logic [CNT_W-1:0]    n_count;
    logic [CNT_W-1:0]    n_left;
    logic                n_open;
    logic                n_exceeded;
    logic [TICK_W-1:0]   n_elapsed;
    logic                n_out_valid;
    logic [INDEX_W-1:0]  n_out_index;
    logic                n_out_window;
    logic                n_out_last;

    logic                w_accept;
    logic                w_out_free;
    logic [STORE_BITS-1:0] w_key;
    logic [TICK_W-1:0]   w_len;
    logic [TICK_W-1:0]   w_elapsed_inc;
    logic                w_any_match;
    logic                w_store;
    logic                w_shift;
    t_mode               w_mode;

    logic [STORE_BITS-1:0] w_cell_data [MAX_DISTINCT];
    logic [MAX_DISTINCT-1:0] w_match;

    assign w_mode     = t_mode'(i_mode);
    assign w_key      = i_param_index[STORE_BITS-1:0];
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state == ST_DRAIN) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Window length of zero acts as one
    assign w_len = (r_window_ticks == '0) ? TICK_W'(1) : r_window_ticks;
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + TICK_W'(1);

    assign w_any_match = |w_match;
    assign w_store = w_accept && (w_mode == MODE_CHANGE) && !i_already_in_layout
                     && !w_any_match && (r_count < CNT_MAX);
    assign w_shift = (r_state == ST_DRAIN) && w_out_free;

    // Cell chain: write at the fill position, shift toward cell 0 while draining
    genvar g;
    generate
        for (g = 0; g < MAX_DISTINCT; g++) begin : g_cell
            logic [STORE_BITS-1:0] w_next;
            if (g == MAX_DISTINCT - 1) begin : g_end
                assign w_next = w_cell_data[g];
            end else begin : g_mid
                assign w_next = w_cell_data[g+1];
            end
            debf_cell #(
                .WIDTH (STORE_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_write    (w_store && (r_count == CNT_W'(g))),
                .i_shift    (w_shift),
                .i_active   (r_count > CNT_W'(g)),
                .i_key      (w_key),
                .i_neighbor (w_next),
                .o_data     (w_cell_data[g]),
                .o_match    (w_match[g])
            );
        end
    endgenerate

    // Event handling, window timer and drain control
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_left       = r_left;
        n_open       = r_open;
        n_exceeded   = r_exceeded;
        n_elapsed    = r_elapsed;
        n_out_valid  = r_out_valid && i_stall;
        n_out_index  = r_out_index;
        n_out_window = r_out_window;
        n_out_last   = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_mode)
                        MODE_GESTURE: begin
                            n_out_valid  = 1'b1;
                            n_out_index  = INDEX_W'(w_key);
                            n_out_window = 1'b0;
                            n_out_last   = 1'b1;
                        end
                        MODE_CHANGE: begin
                            if (!i_already_in_layout && !w_any_match) begin
                                if (r_count < CNT_MAX) begin
                                    n_count = r_count + CNT_W'(1);
                                end else begin
                                    n_exceeded = 1'b1;
                                end
                                if (!r_open) begin
                                    n_open    = 1'b1;
                                    n_elapsed = '0;
                                end
                            end
                        end
                        MODE_TICK: begin
                            if (r_open) begin
                                n_elapsed = w_elapsed_inc;
                                if (w_elapsed_inc >= w_len) begin
                                    // Close the window; drain only a clean one
                                    if (!r_exceeded && (r_count != '0)) begin
                                        n_left  = r_count;
                                        n_state = ST_DRAIN;
                                    end
                                    n_count    = '0;
                                    n_open     = 1'b0;
                                    n_exceeded = 1'b0;
                                    n_elapsed  = '0;
                                end
                            end
                        end
                        MODE_DISARM: begin
                            n_count    = '0;
                            n_open     = 1'b0;
                            n_exceeded = 1'b0;
                            n_elapsed  = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                // Move the head of the chain into the output stage
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = INDEX_W'(w_cell_data[0]);
                    n_out_window = 1'b1;
                    n_out_last   = (r_left == CNT_W'(1));
                    n_left       = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_window_ticks <= WINDOW_TICKS_RST;
            r_count        <= '0;
            r_left         <= '0;
            r_open         <= 1'b0;
            r_exceeded     <= 1'b0;
            r_elapsed      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_open      <= n_open;
            r_exceeded  <= n_exceeded;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window_ticks <= i_cfg_data;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_index  <= n_out_index;
        r_out_window <= n_out_window;
        r_out_last   <= n_out_last;
    end

    assign o_valid         = r_out_valid;
    assign o_touched_index = r_out_index;
    assign o_from_window   = r_out_window;
    assign o_last          = r_out_last;

endmodule

// ===== hw/rtl/debf_cell.sv =====
// One candidate cell: holds a stored index, compares it, hands it to its neighbor.
module debf_cell
    import debf_pkg::*;
#(
    parameter int WIDTH = INDEX_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_write,
    input  logic             i_shift,
    input  logic             i_active,
    input  logic [WIDTH-1:0] i_key,
    input  logic [WIDTH-1:0] i_neighbor,
    output logic [WIDTH-1:0] o_data,
    output logic             o_match
);

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;

    // Load a new candidate, or take the neighbor's entry while draining
    always_comb begin
        n_data = r_data;
        if (i_write) begin
            n_data = i_key;
        end else if (i_shift) begin
            n_data = i_neighbor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = i_active && (r_data == i_key);

endmodule
